// File: rtl/mpmc_pkg.sv
package mpmc_pkg;

	localparam int MAX_NODES_DEF = 256;
	localparam int ALPHABET_DEF = 256;

	localparam int OP_W = 3;
	localparam int SYM_W = 8;
	localparam int ST_W = 2;
	localparam int COUNT_W = 16;

	localparam logic [OP_W-1:0] OP_PAT_BYTE = 3'd0;
	localparam logic [OP_W-1:0] OP_PAT_END = 3'd1;
	localparam logic [OP_W-1:0] OP_FINALIZE = 3'd2;
	localparam logic [OP_W-1:0] OP_TEXT_BYTE = 3'd3;
	localparam logic [OP_W-1:0] OP_TEXT_END = 3'd4;

	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_NOT_FINAL = 2'd2;
	localparam logic [ST_W-1:0] ST_AFTER_FINAL = 2'd3;

endpackage

// File: rtl/mpmc_ram.sv
module mpmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/multi_pattern_match_counter_core.sv
// Multi-pattern match counter built on an Aho-Corasick automaton.
// Commands enter on start/operation/symbol and are taken when start is high
// and busy is low. Each command gives exactly one result, shown for one cycle
// with strobe high; the receiver cannot stall, so results are never held.
// Patterns are entered byte by byte and closed with an end-pattern command.
// Finalize builds failure links, the full transition table and per-node match
// totals in a breadth-first walk over every alphabet symbol of each node, paced
// by the single read port of the transition memory. A text byte reads its
// transition, then the node total, then adds; a pattern byte reads its
// transition, then follows it or adds a node; other commands answer directly.
// After reset the transition memory and end-of-pattern marks are cleared by a
// pass over all MAX_NODES * 2**clog2(ALPHABET) entries with busy high. The
// threshold register is set via cfg_valid/cfg_data, always ready; the user
// must write it only while no command is in flight: the block does not check.
module multi_pattern_match_counter_core #(
	parameter int MAX_NODES = mpmc_pkg::MAX_NODES_DEF,
	parameter int ALPHABET = mpmc_pkg::ALPHABET_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [mpmc_pkg::OP_W-1:0]     operation,
	input  logic [mpmc_pkg::SYM_W-1:0]    symbol,
	output logic                          strobe,
	output logic [mpmc_pkg::ST_W-1:0]     status,
	output logic [mpmc_pkg::COUNT_W-1:0]  match_count,
	output logic                          meets_threshold,
	output logic                          text_done,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mpmc_pkg::COUNT_W-1:0]  cfg_data
);

	import mpmc_pkg::*;

	localparam int NW = $clog2(MAX_NODES);
	localparam int AW = $clog2(ALPHABET);
	localparam int TW = NW + AW;
	localparam int TDEPTH = MAX_NODES << AW;

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_PB_WAIT = 4'd2;
	localparam logic [3:0] S_TB_WAIT = 4'd3;
	localparam logic [3:0] S_TB_TOT = 4'd4;
	localparam logic [3:0] S_F_POP = 4'd5;
	localparam logic [3:0] S_F_U = 4'd6;
	localparam logic [3:0] S_F_F = 4'd7;
	localparam logic [3:0] S_F_RDV = 4'd8;
	localparam logic [3:0] S_F_RDVIA = 4'd9;
	localparam logic [3:0] S_F_DEC = 4'd10;
	localparam logic [3:0] S_F_TOT = 4'd11;

	logic [3:0] state_q;
	logic [TW-1:0] clr_q;
	logic [AW-1:0] sym_m, sym_q;
	logic [NW:0] used_q;
	logic [NW-1:0] cur_q, scan_q, head_q, tail_q, u_q, f_q, v_q, via_q;
	logic [AW-1:0] c_q;
	logic failed_q, fin_q, root_q;
	logic [COUNT_W-1:0] run_q, min_q;
	logic strobe_q, meets_q, done_q;
	logic [ST_W-1:0] status_q;
	logic [COUNT_W-1:0] count_q;

	logic t_we;
	logic [TW-1:0] t_wa, t_ra;
	logic [NW-1:0] t_wd, t_rd;
	logic f_we;
	logic [NW-1:0] f_wa, f_wd, f_ra, f_rd;
	logic m_we;
	logic [NW-1:0] m_wa, m_ra;
	logic m_wd, m_rd;
	logic o_we;
	logic [NW-1:0] o_wa, o_wd, o_ra, o_rd;
	logic q_we;
	logic [NW-1:0] q_wa, q_wd, q_ra, q_rd;
	logic [NW-1:0] via;
	logic [COUNT_W:0] sum;
	logic accept;

	always_comb begin
		sym_m = '0;
		for (int i = 0; i < 256; i++) begin
			if (symbol == SYM_W'(i)) begin
				sym_m = AW'(i % ALPHABET);
			end
		end
	end

	assign accept = start && (state_q == S_IDLE);
	assign via = root_q ? '0 : t_rd;
	assign sum = {1'b0, run_q} + (COUNT_W + 1)'((scan_q == '0) ? '0 : o_rd);

	always_comb begin
		t_we = 1'b0; t_wa = {cur_q, sym_q}; t_wd = used_q[NW-1:0];
		t_ra = {cur_q, sym_m};
		f_we = 1'b0; f_wa = v_q; f_wd = via; f_ra = q_rd;
		m_we = 1'b0; m_wa = cur_q; m_wd = 1'b1; m_ra = v_q;
		o_we = 1'b0; o_wa = v_q;
		o_wd = NW'(m_rd) + ((via_q == '0) ? '0 : o_rd);
		o_ra = t_rd;
		q_we = 1'b0; q_wa = tail_q; q_wd = v_q; q_ra = head_q;
		unique case (state_q)
			S_CLEAR: begin
				t_we = 1'b1; t_wa = clr_q; t_wd = '0;
				m_we = 1'b1; m_wa = clr_q[TW-1:AW]; m_wd = 1'b0;
			end
			S_IDLE: begin
				if (operation == OP_TEXT_BYTE) begin
					t_ra = {scan_q, sym_m};
				end
				if (accept && operation == OP_PAT_END && !fin_q && !failed_q
						&& cur_q != '0) begin
					m_we = 1'b1;
				end
			end
			S_PB_WAIT: begin
				if (t_rd == '0 && used_q < (NW + 1)'(MAX_NODES)) begin
					t_we = 1'b1;
				end
			end
			S_F_RDV: t_ra = {u_q, c_q};
			S_F_RDVIA: t_ra = {f_q, c_q};
			S_F_DEC: begin
				o_ra = via;
				if (v_q != '0) begin
					f_we = 1'b1;
				end else if (!root_q) begin
					t_we = 1'b1; t_wa = {u_q, c_q}; t_wd = via;
				end
			end
			S_F_TOT: begin
				o_we = 1'b1;
				q_we = 1'b1;
			end
			default: ;
		endcase
	end

	mpmc_ram #(.WIDTH(NW), .DEPTH(TDEPTH)) u_trans (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
	mpmc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_fail (
		.clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
	mpmc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_term (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
	mpmc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_total (
		.clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
	mpmc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd), .raddr(q_ra), .rdata(q_rd));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			used_q <= (NW + 1)'(1);
			cur_q <= '0;
			scan_q <= '0;
			failed_q <= 1'b0;
			fin_q <= 1'b0;
			root_q <= 1'b0;
			run_q <= '0;
			min_q <= COUNT_W'(4);
			strobe_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			c_q <= '0;
			sym_q <= '0;
			status_q <= ST_OK;
			count_q <= '0;
			meets_q <= 1'b0;
			done_q <= 1'b0;
			u_q <= '0;
			f_q <= '0;
			v_q <= '0;
			via_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (cfg_valid) begin
				min_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TW'(1);
					if (clr_q == TW'(TDEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						sym_q <= sym_m;
						status_q <= ST_OK;
						count_q <= run_q;
						meets_q <= 1'b0;
						done_q <= 1'b0;
						case (operation)
							OP_PAT_BYTE: begin
								if (fin_q) begin
									status_q <= ST_AFTER_FINAL;
									strobe_q <= 1'b1;
								end else if (failed_q) begin
									status_q <= ST_FULL;
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_PB_WAIT;
								end
							end
							OP_PAT_END: begin
								strobe_q <= 1'b1;
								if (fin_q) begin
									status_q <= ST_AFTER_FINAL;
								end else begin
									if (failed_q) begin
										status_q <= ST_FULL;
									end
									failed_q <= 1'b0;
									cur_q <= '0;
								end
							end
							OP_FINALIZE: begin
								if (fin_q) begin
									strobe_q <= 1'b1;
								end else begin
									cur_q <= '0;
									failed_q <= 1'b0;
									root_q <= 1'b1;
									u_q <= '0;
									f_q <= '0;
									c_q <= '0;
									head_q <= '0;
									tail_q <= '0;
									state_q <= S_F_RDV;
								end
							end
							OP_TEXT_BYTE: begin
								if (!fin_q) begin
									status_q <= ST_NOT_FINAL;
									strobe_q <= 1'b1;
								end else begin
									state_q <= S_TB_WAIT;
								end
							end
							OP_TEXT_END: begin
								strobe_q <= 1'b1;
								done_q <= 1'b1;
								if (!fin_q) begin
									status_q <= ST_NOT_FINAL;
								end else begin
									meets_q <= (run_q >= min_q);
								end
								scan_q <= '0;
								run_q <= '0;
							end
							default: strobe_q <= 1'b1;
						endcase
					end
				end
				S_PB_WAIT: begin
					strobe_q <= 1'b1;
					state_q <= S_IDLE;
					if (t_rd != '0) begin
						cur_q <= t_rd;
					end else if (used_q < (NW + 1)'(MAX_NODES)) begin
						cur_q <= used_q[NW-1:0];
						used_q <= used_q + (NW + 1)'(1);
					end else begin
						failed_q <= 1'b1;
						status_q <= ST_FULL;
					end
				end
				S_TB_WAIT: begin
					scan_q <= t_rd;
					state_q <= S_TB_TOT;
				end
				S_TB_TOT: begin
					run_q <= sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
					count_q <= sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
					strobe_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_F_POP: begin
					root_q <= 1'b0;
					if (head_q == tail_q) begin
						fin_q <= 1'b1;
						strobe_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						head_q <= head_q + NW'(1);
						state_q <= S_F_U;
					end
				end
				S_F_U: begin
					u_q <= q_rd;
					state_q <= S_F_F;
				end
				S_F_F: begin
					f_q <= f_rd;
					c_q <= '0;
					state_q <= S_F_RDV;
				end
				S_F_RDV: state_q <= S_F_RDVIA;
				S_F_RDVIA: begin
					v_q <= t_rd;
					state_q <= S_F_DEC;
				end
				S_F_DEC: begin
					via_q <= via;
					if (v_q != '0) begin
						state_q <= S_F_TOT;
					end else if (c_q == AW'(ALPHABET - 1)) begin
						state_q <= S_F_POP;
					end else begin
						c_q <= c_q + AW'(1);
						state_q <= S_F_RDV;
					end
				end
				S_F_TOT: begin
					tail_q <= tail_q + NW'(1);
					if (c_q == AW'(ALPHABET - 1)) begin
						state_q <= S_F_POP;
					end else begin
						c_q <= c_q + AW'(1);
						state_q <= S_F_RDV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign strobe = strobe_q;
	assign status = status_q;
	assign match_count = count_q;
	assign meets_threshold = meets_q;
	assign text_done = done_q;

endmodule
